### rtl/core/arp_pkg.sv
// Package: constants and types shared by the ARP resolver
`timescale 1ns / 1ps

package arp_pkg;

    localparam int CACHE_ENTRIES = 16;
    localparam int IDX_W         = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
    localparam int FILL_W        = $clog2(CACHE_ENTRIES + 1);
    localparam int ADDR_W        = 3;

    localparam logic [7:0] BCAST_MAC = 8'd255;

    localparam logic [1:0] PKT_IP  = 2'd0;
    localparam logic [1:0] PKT_REQ = 2'd1;
    localparam logic [1:0] PKT_REP = 2'd2;

    localparam logic MODE_HOST = 1'b0;
    localparam logic MODE_WIRE = 1'b1;

    localparam logic DEST_WIRE = 1'b0;
    localparam logic DEST_HOST = 1'b1;

    localparam logic REG_OWN_IP  = 1'b0;
    localparam logic REG_OWN_MAC = 1'b1;

    localparam logic [7:0] OWN_MAC_RESET = 8'd1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DECIDE,
        S_SCAN,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic        mode;
        logic [1:0]  pkt_type;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  src_mac;
        logic [7:0]  dst_mac;
        logic [31:0] tag;
    } t_item;

    typedef struct packed {
        logic        dest;
        logic [1:0]  pkt_type;
        logic [31:0] src_ip;
        logic [31:0] dst_ip;
        logic [7:0]  src_mac;
        logic [7:0]  dst_mac;
        logic [31:0] tag;
    } t_pkt;

    typedef struct packed {
        logic [31:0] ip;
        logic [7:0]  mac;
    } t_cache_entry;

endpackage

### rtl/core/arp_address_resolver.sv
// ARP address resolver: packet event decoder, IP-to-MAC cache scan and result register
//
// Input channel: i_in_valid with o_in_stall; one beat is one packet event (i_mode,
// i_pkt_type, header fields, i_payload_tag), taken when i_in_valid is high and
// o_in_stall is low. o_in_stall stays high while an event is in work.
// Output channel: o_out_valid with i_out_stall; one beat is one emitted packet.
// An event gives zero or one output beat.
// Configuration: APB registers own_ip (address 0) and own_mac (address 4);
// pready is always high.
// Timing: events that need no cache lookup go from the decode step straight to the
// emit step. Lookups walk the cache with one comparator, one entry per cycle;
// a hit loads the output register when the walk reaches the matching entry, a miss
// once the walk has passed all entries written so far (fill, at most 16).
// The next event is accepted once the result is loaded into the output register
// and the state is back in idle; an event without a result frees the input after
// the decode step.
// A waiting output beat does not block intake; a second result waits in the
// emit step until the receiver takes the first.
// Reset (synchronous, active low) empties the cache and the pending slot,
// clears own_ip to 0 and sets own_mac to 1.
`timescale 1ns / 1ps

module arp_address_resolver (
    input  logic                       i_clk,
    input  logic                       i_rst_n,

    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  logic                       i_mode,
    input  logic [1:0]                 i_pkt_type,
    input  logic [31:0]                i_src_ip,
    input  logic [31:0]                i_dst_ip,
    input  logic [7:0]                 i_src_mac,
    input  logic [7:0]                 i_dst_mac,
    input  logic [31:0]                i_payload_tag,

    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output logic                       o_out_dest,
    output logic [1:0]                 o_out_type,
    output logic [31:0]                o_out_src_ip,
    output logic [31:0]                o_out_dst_ip,
    output logic [7:0]                 o_out_src_mac,
    output logic [7:0]                 o_out_dst_mac,
    output logic [31:0]                o_out_payload_tag,

    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [arp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                pwdata,
    output logic [31:0]                prdata,
    output logic                       pready
);

    arp_pkg::t_state       r_state, n_state;
    arp_pkg::t_item        r_in;
    arp_pkg::t_pkt         r_res, n_res;
    arp_pkg::t_pkt         r_out;
    logic                  r_out_valid, n_out_valid;
    logic                  w_out_load;

    logic [31:0]           r_own_ip;
    logic [7:0]            r_own_mac;

    arp_pkg::t_cache_entry r_cache_mem [arp_pkg::CACHE_ENTRIES];
    arp_pkg::t_cache_entry r_rd_entry;
    logic                  r_rd_valid, n_rd_valid;
    logic                  r_primed, n_primed;
    logic [arp_pkg::FILL_W-1:0] r_idx, n_idx;
    logic [arp_pkg::FILL_W-1:0] r_fill, n_fill;
    logic                  w_cache_wr;
    logic [31:0]           r_key, n_key;
    logic                  r_from_pend, n_from_pend;
    logic                  w_hit;

    logic                  r_pend_valid, n_pend_valid;
    logic                  w_pend_load;
    logic [31:0]           r_pend_src_ip;
    logic [31:0]           r_pend_dst_ip;
    logic [7:0]            r_pend_src_mac;
    logic [31:0]           r_pend_tag;

    logic                  w_in_accept;
    logic                  w_cfg_write;

    assign w_in_accept = i_in_valid && !o_in_stall;
    assign o_in_stall  = (r_state != arp_pkg::S_IDLE);
    assign w_cfg_write = psel && penable && pwrite && pready;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == arp_pkg::REG_OWN_MAC) ? {24'd0, r_own_mac} : r_own_ip;

    // shared comparator for the cache walk
    assign w_hit = (r_rd_entry.ip == r_key);

    always_comb begin
        n_state      = r_state;
        n_res        = r_res;
        n_idx        = r_idx;
        n_primed     = r_primed;
        n_rd_valid   = r_rd_valid;
        n_key        = r_key;
        n_from_pend  = r_from_pend;
        n_fill       = r_fill;
        n_pend_valid = r_pend_valid;
        n_out_valid  = r_out_valid && i_out_stall;
        w_cache_wr   = 1'b0;
        w_pend_load  = 1'b0;
        w_out_load   = 1'b0;
        unique case (r_state)
            arp_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_state = arp_pkg::S_DECIDE;
                end
            end
            arp_pkg::S_DECIDE: begin
                n_state    = arp_pkg::S_IDLE;
                n_idx      = '0;
                n_primed   = 1'b0;
                n_rd_valid = 1'b0;
                priority if (r_in.pkt_type != arp_pkg::PKT_IP &&
                             r_in.pkt_type != arp_pkg::PKT_REQ &&
                             r_in.pkt_type != arp_pkg::PKT_REP) begin
                    n_state = arp_pkg::S_IDLE;
                end else if (r_in.mode == arp_pkg::MODE_HOST) begin
                    if (r_in.pkt_type != arp_pkg::PKT_IP) begin
                        n_res = '{dest: arp_pkg::DEST_WIRE, pkt_type: r_in.pkt_type,
                                  src_ip: r_in.src_ip, dst_ip: r_in.dst_ip,
                                  src_mac: r_in.src_mac, dst_mac: r_in.dst_mac,
                                  tag: 32'd0};
                        n_state = arp_pkg::S_EMIT;
                    end else begin
                        n_key       = r_in.dst_ip;
                        n_from_pend = 1'b0;
                        n_state     = arp_pkg::S_SCAN;
                    end
                end else if (r_in.pkt_type == arp_pkg::PKT_IP) begin
                    if (r_in.dst_mac == r_own_mac) begin
                        n_res = '{dest: arp_pkg::DEST_HOST, pkt_type: arp_pkg::PKT_IP,
                                  src_ip: r_in.src_ip, dst_ip: r_in.dst_ip,
                                  src_mac: r_in.src_mac, dst_mac: r_in.dst_mac,
                                  tag: r_in.tag};
                        n_state = arp_pkg::S_EMIT;
                    end
                end else if (r_in.pkt_type == arp_pkg::PKT_REQ) begin
                    if (r_in.dst_ip == r_own_ip) begin
                        n_res = '{dest: arp_pkg::DEST_WIRE, pkt_type: arp_pkg::PKT_REP,
                                  src_ip: r_own_ip, dst_ip: r_in.src_ip,
                                  src_mac: r_own_mac, dst_mac: r_in.src_mac,
                                  tag: 32'd0};
                        n_state = arp_pkg::S_EMIT;
                    end
                end else if (r_in.dst_mac == r_own_mac) begin
                    if (r_fill < arp_pkg::FILL_W'(arp_pkg::CACHE_ENTRIES)) begin
                        w_cache_wr = 1'b1;
                        n_fill     = r_fill + arp_pkg::FILL_W'(1);
                    end
                    if (r_pend_valid) begin
                        n_pend_valid = 1'b0;
                        n_key        = r_pend_dst_ip;
                        n_from_pend  = 1'b1;
                        n_state      = arp_pkg::S_SCAN;
                    end
                end
            end
            arp_pkg::S_SCAN: begin
                n_idx      = r_idx + arp_pkg::FILL_W'(1);
                n_rd_valid = (r_idx < r_fill);
                n_primed   = 1'b1;
                if (r_primed) begin
                    if (!r_rd_valid) begin
                        n_state = arp_pkg::S_EMIT;
                        if (r_from_pend) begin
                            n_res = '{dest: arp_pkg::DEST_WIRE, pkt_type: arp_pkg::PKT_IP,
                                      src_ip: r_pend_src_ip, dst_ip: r_pend_dst_ip,
                                      src_mac: r_pend_src_mac, dst_mac: r_in.src_mac,
                                      tag: r_pend_tag};
                        end else begin
                            w_pend_load  = 1'b1;
                            n_pend_valid = 1'b1;
                            n_res = '{dest: arp_pkg::DEST_WIRE, pkt_type: arp_pkg::PKT_REQ,
                                      src_ip: r_in.src_ip, dst_ip: r_in.dst_ip,
                                      src_mac: r_in.src_mac, dst_mac: arp_pkg::BCAST_MAC,
                                      tag: 32'd0};
                        end
                    end else if (w_hit) begin
                        n_state = arp_pkg::S_EMIT;
                        if (r_from_pend) begin
                            n_res = '{dest: arp_pkg::DEST_WIRE, pkt_type: arp_pkg::PKT_IP,
                                      src_ip: r_pend_src_ip, dst_ip: r_pend_dst_ip,
                                      src_mac: r_pend_src_mac, dst_mac: r_rd_entry.mac,
                                      tag: r_pend_tag};
                        end else begin
                            n_res = '{dest: arp_pkg::DEST_WIRE, pkt_type: arp_pkg::PKT_IP,
                                      src_ip: r_in.src_ip, dst_ip: r_in.dst_ip,
                                      src_mac: r_in.src_mac, dst_mac: r_rd_entry.mac,
                                      tag: r_in.tag};
                        end
                    end
                end
            end
            arp_pkg::S_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    w_out_load  = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = arp_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = arp_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= arp_pkg::S_IDLE;
            r_out_valid  <= 1'b0;
            r_fill       <= '0;
            r_pend_valid <= 1'b0;
            r_idx        <= '0;
            r_primed     <= 1'b0;
            r_rd_valid   <= 1'b0;
            r_from_pend  <= 1'b0;
            r_own_ip     <= 32'd0;
            r_own_mac    <= arp_pkg::OWN_MAC_RESET;
        end else begin
            r_state      <= n_state;
            r_out_valid  <= n_out_valid;
            r_fill       <= n_fill;
            r_pend_valid <= n_pend_valid;
            r_idx        <= n_idx;
            r_primed     <= n_primed;
            r_rd_valid   <= n_rd_valid;
            r_from_pend  <= n_from_pend;
            if (w_cfg_write) begin
                if (paddr[2] == arp_pkg::REG_OWN_MAC) begin
                    r_own_mac <= pwdata[7:0];
                end else begin
                    r_own_ip <= pwdata;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        r_key <= n_key;
        if (w_in_accept) begin
            r_in <= '{mode: i_mode, pkt_type: i_pkt_type, src_ip: i_src_ip,
                      dst_ip: i_dst_ip, src_mac: i_src_mac, dst_mac: i_dst_mac,
                      tag: i_payload_tag};
        end
        if (w_out_load) begin
            r_out <= r_res;
        end
        if (w_pend_load) begin
            r_pend_src_ip  <= r_in.src_ip;
            r_pend_dst_ip  <= r_in.dst_ip;
            r_pend_src_mac <= r_in.src_mac;
            r_pend_tag     <= r_in.tag;
        end
    end

    // cache memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (w_cache_wr) begin
            r_cache_mem[r_fill[arp_pkg::IDX_W-1:0]] <= '{ip: r_in.src_ip, mac: r_in.src_mac};
        end
        r_rd_entry <= r_cache_mem[r_idx[arp_pkg::IDX_W-1:0]];
    end

    assign o_out_valid       = r_out_valid;
    assign o_out_dest        = r_out.dest;
    assign o_out_type        = r_out.pkt_type;
    assign o_out_src_ip      = r_out.src_ip;
    assign o_out_dst_ip      = r_out.dst_ip;
    assign o_out_src_mac     = r_out.src_mac;
    assign o_out_dst_mac     = r_out.dst_mac;
    assign o_out_payload_tag = r_out.tag;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= arp_pkg::FILL_W'(arp_pkg::CACHE_ENTRIES))
        else $error("cache fill beyond capacity");

    a_fill_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && r_fill != $past(r_fill)) |->
        (r_fill == $past(r_fill) + arp_pkg::FILL_W'(1)))
        else $error("cache fill moved by more than one");

    a_pend_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $rose(r_pend_valid)) |->
        ($past(r_state) == arp_pkg::S_SCAN && !$past(r_from_pend)))
        else $error("pending slot filled outside a host lookup miss");

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_accept |=> (r_state == arp_pkg::S_DECIDE))
        else $error("accepted beat not decoded");

    a_out_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || !i_out_stall))
        else $error("output register overwritten while held");

endmodule
